// ===== hdl/mlm_pkg.sv =====
// Shared types and constants for the message link mailbox.
// Holds the item structs, the state and code enums and the queue byte selection.
// Depends on nothing; the files that use it refer to it by scoped names.
package mlm_pkg;

  // Kind of an input item.
  typedef enum logic [2:0] {
    KIND_DATA_WR     = 3'd0,
    KIND_DATA_RD     = 3'd1,
    KIND_FLAGS_WR    = 3'd2,
    KIND_FLAGS_RD    = 3'd3,
    KIND_TICK        = 3'd4,
    KIND_SERVER_START = 3'd5,
    KIND_SERVER_BYTE = 3'd6
  } kind_t;

  // What a result tells the server side.
  typedef enum logic [1:0] {
    SEND_NONE  = 2'd0,
    SEND_BYTE  = 2'd1,
    SEND_LAST  = 2'd2,
    SEND_EMPTY = 2'd3
  } send_code_t;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ_ADDR,
    ST_READ_DATA,
    ST_OUT
  } state_t;

  // Byte sequences that the push loop writes into the reply queue.
  typedef enum logic [1:0] {
    SEQ_PING,
    SEQ_STATUS,
    SEQ_SERVER_HDR,
    SEQ_SERVER_BYTE
  } seq_t;

  // Frame commands.
  localparam logic [7:0] CMD_PING   = 8'd3;
  localparam logic [7:0] CMD_STATUS = 8'd4;
  localparam logic [7:0] CMD_SEND   = 8'd7;

  // Bytes that appear in queued headers.
  localparam logic [7:0] REPLY_LEN   = 8'd2;
  localparam logic [7:0] SERVER_TAG  = 8'd7;

  // Flag register bit positions.
  localparam int unsigned FLAG_NONEMPTY = 7;
  localparam int unsigned FLAG_IRQ_EN   = 6;
  localparam int unsigned FLAG_LINK_EN  = 0;

  // Configuration register indexes.
  localparam logic REG_SERVER_CONNECTED = 1'b0;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       irq_line;
    send_code_t send_code;
    logic [7:0] send_byte;
    logic       overflow;
  } out_item_t;

  // Requests to the queue pointer unit.
  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  // Status from the queue pointer unit.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  // Byte number idx of a queued sequence.
  function automatic logic [7:0] seq_byte(seq_t seq, logic [1:0] idx, logic [7:0] last_rd,
                                          logic [7:0] val, logic connected);
    logic [7:0] b;
    b = last_rd;
    unique case (seq)
      SEQ_PING: begin
        unique case (idx)
          2'd0: b = last_rd;
          2'd1: b = REPLY_LEN;
          2'd2: b = CMD_PING;
          default: b = CMD_PING;
        endcase
      end
      SEQ_STATUS: begin
        unique case (idx)
          2'd0: b = last_rd;
          2'd1: b = REPLY_LEN;
          2'd2: b = CMD_STATUS;
          default: b = {7'd0, connected};
        endcase
      end
      SEQ_SERVER_HDR: begin
        unique case (idx)
          2'd0: b = last_rd;
          2'd1: b = val + 8'd1;
          default: b = SERVER_TAG;
        endcase
      end
      SEQ_SERVER_BYTE: b = val;
      default: b = val;
    endcase
    return b;
  endfunction

  // Index of the last byte of a sequence.
  function automatic logic [1:0] seq_last(seq_t seq);
    logic [1:0] n;
    unique case (seq)
      SEQ_PING, SEQ_STATUS: n = 2'd3;
      SEQ_SERVER_HDR:       n = 2'd2;
      default:              n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

// ===== hdl/mlm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Used for the reply queue storage; no dependencies.
module mlm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mlm_queue_ctl.sv =====
// Pointer unit of the reply queue: head, fill count and wrapped tail address.
// Depends on mlm_pkg for the control and status structs.
module mlm_queue_ctl #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  mlm_pkg::queue_ctl_t            ctl,
  output mlm_pkg::queue_stat_t           stat,
  output logic [$clog2(QUEUE_DEPTH)-1:0] head,
  output logic [$clog2(QUEUE_DEPTH)-1:0] tail
);

  localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W = ADDR_W + 1;
  localparam logic [FILL_W-1:0] DEPTH_F = FILL_W'(QUEUE_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_A  = ADDR_W'(QUEUE_DEPTH - 1);

  logic [ADDR_W-1:0] head_r, head_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [FILL_W-1:0] slot_sum;

  // Tail is head plus fill, folded back once past the end.
  always_comb begin
    slot_sum = {1'b0, head_r} + fill_r;
    if (slot_sum >= DEPTH_F) begin
      slot_sum = slot_sum - DEPTH_F;
    end
  end

  assign tail       = slot_sum[ADDR_W-1:0];
  assign head       = head_r;
  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r >= DEPTH_F);

  // Pointer and fill updates.
  always_comb begin
    head_nxt = head_r;
    fill_nxt = fill_r;
    if (ctl.pop && !stat.empty) begin
      head_nxt = (head_r == LAST_A) ? '0 : head_r + 1'b1;
      fill_nxt = fill_nxt - 1'b1;
    end
    if (ctl.push && !stat.full) begin
      fill_nxt = fill_nxt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      fill_r <= '0;
    end else begin
      head_r <= head_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule

// ===== hdl/message_link_mailbox_top.sv =====
// Top level of the message link mailbox: sequencer, framing and status registers.
// Depends on mlm_pkg, mlm_queue_ctl and mlm_ram.
//
// The block takes one item at a time and holds in_stall high while it works.
// Flag accesses, ticks, framed data writes that queue nothing and kind 7 go
// straight to ST_OUT, as does a data read on an empty queue; any other read
// passes ST_READ_ADDR and ST_READ_DATA, since the queue memory has a registered
// read. A frame that ends in a reply queues its four bytes one per cycle
// through the single queue write port, as do a server start and a server
// byte with theirs. The next item can be taken while a result still waits
// on the output register. The reply queue needs no clearing after reset.
module message_link_mailbox_top #(
  parameter int unsigned QUEUE_DEPTH = 1024
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input channel.
  input  logic               in_valid,
  output logic               in_stall,
  input  mlm_pkg::in_item_t  in_data,
  // Result channel.
  output logic               out_valid,
  input  logic               out_stall,
  output mlm_pkg::out_item_t out_data,
  // Configuration port.
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned ADDR_W = $clog2(QUEUE_DEPTH);

  mlm_pkg::state_t     state_r, state_nxt;
  mlm_pkg::seq_t       seq_r, seq_nxt;
  logic [1:0]          idx_r, idx_nxt;
  logic [7:0]          val_r, val_nxt;
  logic [7:0]          last_rd_r, last_rd_nxt;
  logic [8:0]          total_r, total_nxt;
  logic [8:0]          pos_r, pos_nxt;
  logic [7:0]          cmd_r, cmd_nxt;
  logic                link_en_r, link_en_nxt;
  logic                irq_en_r, irq_en_nxt;
  logic                irq_lvl_r, irq_lvl_nxt;
  logic                conn_r;
  logic [7:0]          res_read_r, res_read_nxt;
  mlm_pkg::send_code_t res_code_r, res_code_nxt;
  logic [7:0]          res_byte_r, res_byte_nxt;
  logic                drop_r, drop_nxt;
  logic                out_valid_r, out_valid_nxt;
  mlm_pkg::out_item_t  out_data_r, out_data_nxt;

  mlm_pkg::queue_ctl_t  q_ctl;
  mlm_pkg::queue_stat_t q_stat;
  logic [ADDR_W-1:0]    q_head;
  logic [ADDR_W-1:0]    q_tail;
  logic                 ram_wr_en;
  logic [7:0]           ram_wr_data;
  logic                 ram_rd_en;
  logic [7:0]           ram_rd_data;

  logic                 in_xfer;
  logic                 cfg_wr;
  logic [8:0]           pos_inc;
  logic [8:0]           total_new;
  logic [7:0]           cmd_new;

  // The block takes a new item only while the sequencer is idle.
  assign in_stall = (state_r != mlm_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign pready   = 1'b1;
  assign prdata  = (paddr[2] == mlm_pkg::REG_SERVER_CONNECTED) ? {31'd0, conn_r} : 32'd0;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r <= 1'b0;
    end else if (cfg_wr && paddr[2] == mlm_pkg::REG_SERVER_CONNECTED) begin
      conn_r <= pwdata[0];
    end
  end

  // Queue pointers and storage.
  mlm_queue_ctl #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_queue_ctl (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (q_ctl),
    .stat (q_stat),
    .head (q_head),
    .tail (q_tail)
  );

  mlm_ram #(
    .WIDTH(8),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue_ram (
    .clk    (clk),
    .wr_en  (ram_wr_en),
    .wr_addr(q_tail),
    .wr_data(ram_wr_data),
    .rd_en  (ram_rd_en),
    .rd_addr(q_head),
    .rd_data(ram_rd_data)
  );

  // Framing arithmetic for a data write.
  assign pos_inc   = pos_r + 9'd1;
  assign total_new = (pos_r == 9'd0) ? ({1'b0, in_data.value} + 9'd1) : total_r;
  assign cmd_new   = (pos_r == 9'd1) ? in_data.value : cmd_r;

  // Sequencer: next state, queue requests and result values.
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    last_rd_nxt   = last_rd_r;
    total_nxt     = total_r;
    pos_nxt       = pos_r;
    cmd_nxt       = cmd_r;
    link_en_nxt   = link_en_r;
    irq_en_nxt    = irq_en_r;
    irq_lvl_nxt   = irq_lvl_r;
    res_read_nxt  = res_read_r;
    res_code_nxt  = res_code_r;
    res_byte_nxt  = res_byte_r;
    drop_nxt      = drop_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    q_ctl         = '0;
    ram_wr_en     = 1'b0;
    ram_rd_en     = 1'b0;
    ram_wr_data   = mlm_pkg::seq_byte(seq_r, idx_r, last_rd_r, val_r, conn_r);

    unique case (state_r)
      mlm_pkg::ST_IDLE: begin
        if (in_xfer) begin
          res_read_nxt = 8'd0;
          res_code_nxt = mlm_pkg::SEND_NONE;
          res_byte_nxt = 8'd0;
          drop_nxt     = 1'b0;
          val_nxt      = in_data.value;
          idx_nxt      = 2'd0;
          state_nxt    = mlm_pkg::ST_OUT;
          unique case (in_data.kind)
            mlm_pkg::KIND_DATA_WR: begin
              total_nxt = total_new;
              cmd_nxt   = cmd_new;
              // Outgoing payload of a send frame.
              if (pos_r == 9'd1) begin
                if (total_r == 9'd2 && in_data.value == mlm_pkg::CMD_SEND && conn_r) begin
                  res_code_nxt = mlm_pkg::SEND_EMPTY;
                end
              end else if (pos_r != 9'd0 && cmd_r == mlm_pkg::CMD_SEND && conn_r) begin
                res_code_nxt = (pos_inc == total_r) ? mlm_pkg::SEND_LAST
                                                    : mlm_pkg::SEND_BYTE;
                res_byte_nxt = in_data.value;
              end
              // End of frame: queue a reply where the command asks for one.
              if (pos_inc >= total_new) begin
                pos_nxt = 9'd0;
                if (total_new >= 9'd2 && cmd_new == mlm_pkg::CMD_PING) begin
                  seq_nxt   = mlm_pkg::SEQ_PING;
                  state_nxt = mlm_pkg::ST_PUSH;
                end else if (total_new >= 9'd2 && cmd_new == mlm_pkg::CMD_STATUS) begin
                  seq_nxt   = mlm_pkg::SEQ_STATUS;
                  state_nxt = mlm_pkg::ST_PUSH;
                end
              end else begin
                pos_nxt = pos_inc;
              end
            end
            mlm_pkg::KIND_DATA_RD: begin
              if (q_stat.empty) begin
                res_read_nxt = last_rd_r;
              end else begin
                state_nxt = mlm_pkg::ST_READ_ADDR;
              end
            end
            mlm_pkg::KIND_FLAGS_WR: begin
              link_en_nxt = in_data.value[mlm_pkg::FLAG_LINK_EN];
              irq_en_nxt  = in_data.value[mlm_pkg::FLAG_IRQ_EN];
            end
            mlm_pkg::KIND_FLAGS_RD: begin
              res_read_nxt[mlm_pkg::FLAG_NONEMPTY] = !q_stat.empty;
              res_read_nxt[mlm_pkg::FLAG_IRQ_EN]   = irq_en_r;
              res_read_nxt[mlm_pkg::FLAG_LINK_EN]  = link_en_r;
            end
            mlm_pkg::KIND_TICK: begin
              if (irq_en_r) begin
                irq_lvl_nxt = !q_stat.empty;
              end
            end
            mlm_pkg::KIND_SERVER_START: begin
              seq_nxt   = mlm_pkg::SEQ_SERVER_HDR;
              state_nxt = mlm_pkg::ST_PUSH;
            end
            mlm_pkg::KIND_SERVER_BYTE: begin
              seq_nxt   = mlm_pkg::SEQ_SERVER_BYTE;
              state_nxt = mlm_pkg::ST_PUSH;
            end
            default: begin
              state_nxt = mlm_pkg::ST_OUT;
            end
          endcase
        end
      end

      // One queue byte per cycle; a byte that does not fit is dropped.
      mlm_pkg::ST_PUSH: begin
        if (q_stat.full) begin
          drop_nxt = 1'b1;
        end else begin
          ram_wr_en  = 1'b1;
          q_ctl.push = 1'b1;
        end
        idx_nxt = idx_r + 2'd1;
        if (idx_r == mlm_pkg::seq_last(seq_r)) begin
          state_nxt = mlm_pkg::ST_OUT;
        end
      end

      // Read the queue head; the data arrives in ST_READ_DATA from the registered read port.
      mlm_pkg::ST_READ_ADDR: begin
        ram_rd_en = 1'b1;
        state_nxt = mlm_pkg::ST_READ_DATA;
      end

      mlm_pkg::ST_READ_DATA: begin
        last_rd_nxt  = ram_rd_data;
        res_read_nxt = ram_rd_data;
        q_ctl.pop    = 1'b1;
        state_nxt    = mlm_pkg::ST_OUT;
      end

      // Hand the result to the output register once it is free.
      mlm_pkg::ST_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.read_data = res_read_r;
          out_data_nxt.irq_line  = irq_lvl_r;
          out_data_nxt.send_code = res_code_r;
          out_data_nxt.send_byte = res_byte_r;
          out_data_nxt.overflow  = drop_r;
          state_nxt              = mlm_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mlm_pkg::ST_IDLE;
      end
    endcase
  end

  // Control and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mlm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      last_rd_r   <= 8'd0;
      total_r     <= 9'd0;
      pos_r       <= 9'd0;
      cmd_r       <= 8'd0;
      link_en_r   <= 1'b1;
      irq_en_r    <= 1'b1;
      irq_lvl_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_rd_r   <= last_rd_nxt;
      total_r     <= total_nxt;
      pos_r       <= pos_nxt;
      cmd_r       <= cmd_nxt;
      link_en_r   <= link_en_nxt;
      irq_en_r    <= irq_en_nxt;
      irq_lvl_r   <= irq_lvl_nxt;
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    seq_r      <= seq_nxt;
    idx_r      <= idx_nxt;
    val_r      <= val_nxt;
    res_read_r <= res_read_nxt;
    res_code_r <= res_code_nxt;
    res_byte_r <= res_byte_nxt;
    drop_r     <= drop_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== test/tb_message_link_mailbox_top.sv =====
// Self-checking testbench for message_link_mailbox_top: directed and random traffic with an
// item-level predictor, random sender bursts and receiver stalls, and APB setup writes.
// Depends on mlm_pkg and message_link_mailbox_top.
module tb_message_link_mailbox_top;

  localparam int unsigned QUEUE_DEPTH = 1024;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam logic [2:0] CFG_ADDR_CONNECTED = 3'(4 * int'(mlm_pkg::REG_SERVER_CONNECTED));
  // Kind code outside the defined set; the block ignores it.
  localparam mlm_pkg::kind_t KIND_IGNORED = mlm_pkg::kind_t'(3'd7);

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_TOGGLE
  } stall_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  mlm_pkg::in_item_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  mlm_pkg::out_item_t out_data;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Mailbox state as the predictor tracks it.
  logic [7:0] reply_bytes[$];
  logic [7:0] last_read = '0;
  logic [8:0] frame_total = '0;
  logic [8:0] frame_pos = '0;
  logic [7:0] frame_cmd = '0;
  logic       link_en = 1'b1;
  logic       irq_en = 1'b1;
  logic       irq_level = 1'b0;
  logic       server_connected = 1'b0;
  logic       byte_dropped = 1'b0;

  mlm_pkg::out_item_t awaited_results[$];
  int unsigned        mismatches = 0;
  int unsigned        cycle_count = 0;
  int unsigned        burst_left = 0;
  bit                 sender_gaps = 1'b1;
  stall_mode_t        stall_mode = STALL_NONE;
  int unsigned        stall_span = 0;

  message_link_mailbox_top #(.QUEUE_DEPTH(QUEUE_DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // Abort a run that hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL message_link_mailbox_top");
      $finish;
    end
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got, want);
  endtask

  // Appends one byte to the reply queue, or flags it dropped when the queue is full.
  function automatic void queue_byte(input logic [7:0] b);
    if (reply_bytes.size() >= QUEUE_DEPTH)
      byte_dropped = 1'b1;
    else
      reply_bytes.insert(reply_bytes.size(), b);
  endfunction

  // Advances the mailbox state by one item and returns the result it produces.
  function automatic mlm_pkg::out_item_t mailbox_step(input mlm_pkg::in_item_t item);
    mlm_pkg::out_item_t res;
    logic [8:0]         next_pos;
    res = '0;
    byte_dropped = 1'b0;
    case (item.kind)
      mlm_pkg::KIND_DATA_WR: begin
        if (frame_pos == 9'd0) begin
          frame_total = {1'b0, item.value} + 9'd1;
        end else if (frame_pos == 9'd1) begin
          frame_cmd = item.value;
          if (frame_total == 9'd2 && item.value == mlm_pkg::CMD_SEND && server_connected)
            res.send_code = mlm_pkg::SEND_EMPTY;
        end else if (frame_cmd == mlm_pkg::CMD_SEND && server_connected) begin
          res.send_code = (frame_pos + 9'd1 == frame_total) ? mlm_pkg::SEND_LAST
                                                             : mlm_pkg::SEND_BYTE;
          res.send_byte = item.value;
        end
        next_pos = frame_pos + 9'd1;
        if (next_pos >= frame_total) begin
          // A complete frame of at least two bytes may queue a four-byte reply.
          if (frame_total >= 9'd2 &&
              (frame_cmd == mlm_pkg::CMD_PING || frame_cmd == mlm_pkg::CMD_STATUS)) begin
            queue_byte(last_read);
            queue_byte(mlm_pkg::REPLY_LEN);
            queue_byte(frame_cmd);
            queue_byte(frame_cmd == mlm_pkg::CMD_PING ? mlm_pkg::CMD_PING
                                                      : {7'd0, server_connected});
          end
          frame_pos = 9'd0;
        end else begin
          frame_pos = next_pos;
        end
      end
      mlm_pkg::KIND_DATA_RD: begin
        if (reply_bytes.size() > 0) begin
          last_read = reply_bytes[0];
          reply_bytes.delete(0);
        end
        res.read_data = last_read;
      end
      mlm_pkg::KIND_FLAGS_WR: begin
        link_en = item.value[mlm_pkg::FLAG_LINK_EN];
        irq_en = item.value[mlm_pkg::FLAG_IRQ_EN];
      end
      mlm_pkg::KIND_FLAGS_RD: begin
        res.read_data[mlm_pkg::FLAG_NONEMPTY] = reply_bytes.size() > 0;
        res.read_data[mlm_pkg::FLAG_IRQ_EN] = irq_en;
        res.read_data[mlm_pkg::FLAG_LINK_EN] = link_en;
      end
      mlm_pkg::KIND_TICK: begin
        if (irq_en)
          irq_level = reply_bytes.size() > 0;
      end
      mlm_pkg::KIND_SERVER_START: begin
        queue_byte(last_read);
        queue_byte(item.value + 8'd1);
        queue_byte(mlm_pkg::SERVER_TAG);
      end
      mlm_pkg::KIND_SERVER_BYTE: begin
        queue_byte(item.value);
      end
      default: begin
      end
    endcase
    res.irq_line = irq_level;
    res.overflow = byte_dropped;
    return res;
  endfunction

  // Offers one item, waits for its transfer and records the expected result.
  // Valid stays high afterwards so that back-to-back items need no second assignment.
  task automatic send_item(input mlm_pkg::kind_t kind, input logic [7:0] value);
    mlm_pkg::in_item_t item;
    int unsigned       gap;
    item.kind = kind;
    item.value = value;
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (burst_left > 0)
      burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall);
    awaited_results.insert(awaited_results.size(), mailbox_step(item));
  endtask

  // Stops offering items and waits until every expected result has arrived.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Writes the server link register over APB and reads it back.
  task automatic write_connected(input logic on);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_CONNECTED;
    pwdata <= {31'd0, on};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    server_connected = on;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== {31'd0, on})
      report_mismatch("server_connected readback", prdata, {31'd0, on});
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Sends a length-prefixed frame: length byte, command, then len-1 payload bytes.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd);
    int unsigned i;
    send_item(mlm_pkg::KIND_DATA_WR, len);
    if (len > 0)
      send_item(mlm_pkg::KIND_DATA_WR, cmd);
    for (i = 1; i < len; i++)
      send_item(mlm_pkg::KIND_DATA_WR, 8'($urandom));
  endtask

  // Receiver stalls in spans of a randomly chosen style.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_span <= 0;
    end else begin
      if (stall_span == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        stall_span <= $urandom_range(8, 80);
      end else begin
        stall_span <= stall_span - 1;
      end
      case (stall_mode)
        STALL_NONE:  out_stall <= 1'b0;
        STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
        default:     out_stall <= ~out_stall;
      endcase
    end
  end

  // Each result transfer is compared with the oldest expectation.
  always @(posedge clk) begin
    mlm_pkg::out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch("result with nothing awaited", 32'(out_data), 32'd0);
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        if (out_data.read_data !== want.read_data)
          report_mismatch("read_data", 32'(out_data.read_data), 32'(want.read_data));
        if (out_data.irq_line !== want.irq_line)
          report_mismatch("irq_line", 32'(out_data.irq_line), 32'(want.irq_line));
        if (out_data.send_code !== want.send_code)
          report_mismatch("send_code", 32'(out_data.send_code), 32'(want.send_code));
        if (out_data.send_byte !== want.send_byte)
          report_mismatch("send_byte", 32'(out_data.send_byte), 32'(want.send_byte));
        if (out_data.overflow !== want.overflow)
          report_mismatch("overflow", 32'(out_data.overflow), 32'(want.overflow));
      end
    end
  end

  // Status, flags, interrupts and framing corner cases with the link closed.
  task automatic test_directed_controls();
    write_connected(1'b0);
    send_item(mlm_pkg::KIND_DATA_RD, 8'h00);
    send_item(mlm_pkg::KIND_FLAGS_RD, 8'h00);
    send_frame(8'd1, mlm_pkg::CMD_PING);
    send_item(mlm_pkg::KIND_FLAGS_RD, 8'h00);
    send_item(mlm_pkg::KIND_TICK, 8'h00);
    repeat (5) send_item(mlm_pkg::KIND_DATA_RD, 8'hff);
    send_item(mlm_pkg::KIND_TICK, 8'hff);
    // A one-byte message is dropped without effect.
    send_item(mlm_pkg::KIND_DATA_WR, 8'h00);
    send_frame(8'd1, mlm_pkg::CMD_STATUS);
    // Payload with the link closed is discarded.
    send_item(mlm_pkg::KIND_DATA_WR, 8'd2);
    send_item(mlm_pkg::KIND_DATA_WR, mlm_pkg::CMD_SEND);
    send_item(mlm_pkg::KIND_DATA_WR, 8'hff);
    send_frame(8'd3, 8'h80);
    send_item(mlm_pkg::KIND_FLAGS_WR, 8'h00);
    send_item(mlm_pkg::KIND_FLAGS_RD, 8'h00);
    send_item(mlm_pkg::KIND_TICK, 8'h00);
    send_item(mlm_pkg::KIND_FLAGS_WR, 8'hff);
    send_item(mlm_pkg::KIND_FLAGS_RD, 8'h00);
    send_item(KIND_IGNORED, 8'haa);
    // The header length byte wraps for a server start of 255.
    send_item(mlm_pkg::KIND_SERVER_START, 8'hff);
    send_item(mlm_pkg::KIND_SERVER_BYTE, 8'h00);
    send_item(mlm_pkg::KIND_SERVER_BYTE, 8'hff);
    wait_drained();
  endtask

  // Outgoing payload with the link open, including the longest frame.
  task automatic test_connected_send();
    int unsigned i;
    write_connected(1'b1);
    send_frame(8'd1, mlm_pkg::CMD_SEND);
    send_item(mlm_pkg::KIND_DATA_WR, 8'd3);
    send_item(mlm_pkg::KIND_DATA_WR, mlm_pkg::CMD_SEND);
    send_item(mlm_pkg::KIND_DATA_WR, 8'h5a);
    send_item(mlm_pkg::KIND_DATA_WR, 8'ha5);
    send_frame(8'd1, mlm_pkg::CMD_STATUS);
    for (i = 0; i < 16; i++)
      send_item(mlm_pkg::KIND_DATA_RD, 8'h00);
    send_frame(8'd255, mlm_pkg::CMD_SEND);
    for (i = 0; i < 6; i++)
      send_item(mlm_pkg::KIND_DATA_RD, 8'h00);
    wait_drained();
  endtask

  // Fills the reply queue past capacity, then drains it through the wrap point.
  task automatic test_queue_overflow();
    sender_gaps = 1'b0;
    while (reply_bytes.size() < QUEUE_DEPTH)
      send_item(mlm_pkg::KIND_SERVER_START, 8'($urandom));
    send_item(mlm_pkg::KIND_SERVER_BYTE, 8'h3c);
    send_item(mlm_pkg::KIND_SERVER_START, 8'h10);
    send_frame(8'd1, mlm_pkg::CMD_PING);
    send_item(mlm_pkg::KIND_FLAGS_RD, 8'h00);
    send_item(mlm_pkg::KIND_TICK, 8'h00);
    sender_gaps = 1'b1;
    while (reply_bytes.size() > 0)
      send_item(mlm_pkg::KIND_DATA_RD, 8'($urandom));
    send_item(mlm_pkg::KIND_DATA_RD, 8'h00);
    send_item(mlm_pkg::KIND_TICK, 8'h00);
    wait_drained();
  endtask

  // Mostly well-formed frames and server messages, with reads, flags and noise mixed in.
  task automatic random_traffic(input int unsigned item_goal);
    int unsigned sent;
    int unsigned pick;
    int unsigned n;
    int unsigned i;
    logic [7:0]  len;
    logic [7:0]  cmd;
    sent = 0;
    while (sent < item_goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 32) begin
        n = $urandom_range(0, 199);
        if (n < 16) len = 8'd0;
        else if (n < 170) len = 8'($urandom_range(1, 5));
        else if (n < 198) len = 8'($urandom_range(6, 40));
        else len = 8'd255;
        n = $urandom_range(0, 99);
        if (n < 40) cmd = mlm_pkg::CMD_PING;
        else if (n < 60) cmd = mlm_pkg::CMD_STATUS;
        else if (n < 85) cmd = mlm_pkg::CMD_SEND;
        else cmd = 8'($urandom);
        send_frame(len, cmd);
        sent += len + 1;
      end else if (pick < 45) begin
        n = $urandom_range(0, 6);
        send_item(mlm_pkg::KIND_SERVER_START,
                  ($urandom_range(0, 19) == 0) ? 8'hff : 8'(n));
        for (i = 0; i < n; i++)
          send_item(mlm_pkg::KIND_SERVER_BYTE, 8'($urandom));
        sent += n + 1;
      end else if (pick < 75) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++)
          send_item(mlm_pkg::KIND_DATA_RD, 8'($urandom));
        sent += n;
      end else if (pick < 82) begin
        send_item(mlm_pkg::KIND_FLAGS_RD, 8'($urandom));
        sent++;
      end else if (pick < 87) begin
        send_item(mlm_pkg::KIND_FLAGS_WR, 8'($urandom));
        sent++;
      end else if (pick < 94) begin
        send_item(mlm_pkg::KIND_TICK, 8'($urandom));
        sent++;
      end else begin
        send_item(mlm_pkg::kind_t'(3'($urandom_range(0, 7))), 8'($urandom));
        sent++;
      end
    end
  endtask

  // Random traffic in phases, switching the link setting between phases.
  task automatic test_random_traffic();
    int unsigned phase;
    for (phase = 0; phase < 4; phase++) begin
      write_connected(phase[0] == 1'b0);
      random_traffic(50);
      wait_drained();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    test_directed_controls();
    test_connected_send();
    test_queue_overflow();
    test_random_traffic();
    wait_drained();
    if (mismatches == 0) begin
      $display("PASS message_link_mailbox_top");
    end else begin
      $display("FAIL message_link_mailbox_top");
    end
    $finish;
  end

endmodule

// ===== message_link_mailbox_top.f =====
hdl/mlm_pkg.sv
hdl/mlm_ram.sv
hdl/mlm_queue_ctl.sv
hdl/message_link_mailbox_top.sv
test/tb_message_link_mailbox_top.sv
